[rtl/rtdv_pkg.sv]
// Constants, the resistance/temperature table and widths shared by the RTD converter.
package rtdv_pkg;

   // Field widths.
   localparam int VOLT_W = 24;
   localparam int TEMP_W = 15;
   localparam int RES_W  = 18;

   // Voltage span and conversion to milliohms.
   localparam logic signed [VOLT_W-1:0] VOLT_MIN = 24'sd409600;
   localparam logic signed [VOLT_W-1:0] VOLT_MAX = 24'sd1641920;
   localparam int OFF_W      = 21;
   localparam int GAIN_SHIFT = 4;
   localparam logic [RES_W-1:0] RES_BASE = 18'd80310;
   localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = -15'sd5000;

   // Table of resistance (milliohm) and temperature (0.01 C) points.
   localparam int TABLE_POINTS = 14;
   localparam int TBL_STORED   = 14;
   localparam int USED_POINTS  = (TABLE_POINTS > TBL_STORED) ? TBL_STORED :
                                 (TABLE_POINTS < 1) ? 1 : TABLE_POINTS;

   localparam int TBL_R [TBL_STORED] = '{
      80310, 80600, 82500, 100000, 107800, 113000, 115000,
      115500, 123200, 130900, 138500, 150000, 154000, 157330
   };
   localparam int TBL_T [TBL_STORED] = '{
      -5000, -4926, -4447, 0, 2002, 3343, 3860,
      3989, 5989, 8001, 9999, 13045, 14111, 15000
   };

   // Interpolation datapath widths. The widest temperature step is 4447.
   localparam int SPAN_W    = 13;
   // Quotient bits: a multiple of DIV_BITS that covers the widest step.
   localparam int QUOT_W    = 15;
   localparam int PROD_W    = RES_W + SPAN_W;
   localparam int DIV_BITS  = 3;
   localparam int DIV_STAGES = QUOT_W / DIV_BITS;
   localparam int QIDX_W    = $clog2(QUOT_W);

endpackage

[rtl/rtd_voltage_to_temperature_core.sv]
// Pipelined RTD bridge voltage to resistance and temperature converter.
//
// Usage: drive req_adc_microvolt and pulse start; a transaction is accepted
// at each rising edge with start high and busy low. busy stays low, so one
// transaction can be accepted in every cycle.
// Each accepted transaction produces exactly one result: rsp_strobe is high
// for one cycle while rsp_temp_cc and rsp_res_mohm hold it.
// The result is loaded into the output register after passing the stage-1,
// stage-2, product and division registers. Throughput is one transaction per cycle.
// The stages are: clamp and resistance, segment search, multiply, five
// restoring-division stages of three quotient bits each, and the output add.
// The division pipeline sets the latency.
// Reset clears all valid bits, so no result is issued for anything in flight.
// The receiver cannot stall; results are never held or repeated.
module rtd_voltage_to_temperature_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [rtdv_pkg::VOLT_W-1:0]     req_adc_microvolt,
   output logic                                   rsp_strobe,
   output logic signed [rtdv_pkg::TEMP_W-1:0]     rsp_temp_cc,
   output logic        [rtdv_pkg::RES_W-1:0]      rsp_res_mohm
);
   import rtdv_pkg::*;

   // Stage 1: clamp and resistance.
   logic                 s1_vld_ff;
   logic [RES_W-1:0]     s1_res_ff, s1_res_in;

   // Stage 2: segment selection.
   logic                        s2_vld_ff;
   logic [RES_W-1:0]            s2_res_ff;
   logic [RES_W-1:0]            s2_num_ff, s2_num_in;
   logic [RES_W-1:0]            s2_den_ff, s2_den_in;
   logic [SPAN_W-1:0]           s2_span_ff, s2_span_in;
   logic signed [TEMP_W-1:0]    s2_lot_ff, s2_lot_in;

   // Division pipeline; entry 0 is loaded by the multiplier.
   logic                        div_vld_ff [DIV_STAGES+1];
   logic [PROD_W-1:0]           div_rem_ff [DIV_STAGES+1];
   logic [PROD_W-1:0]           div_rem_in [DIV_STAGES+1];
   logic [QUOT_W-1:0]           div_quo_ff [DIV_STAGES+1];
   logic [QUOT_W-1:0]           div_quo_in [DIV_STAGES+1];
   logic [RES_W-1:0]            div_den_ff [DIV_STAGES+1];
   logic signed [TEMP_W-1:0]    div_lot_ff [DIV_STAGES+1];
   logic [RES_W-1:0]            div_res_ff [DIV_STAGES+1];

   // Output register.
   logic                        out_vld_ff;
   logic signed [TEMP_W-1:0]    out_temp_ff, out_temp_in;
   logic [RES_W-1:0]            out_res_ff;

   logic accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Clamp the voltage and scale the offset to milliohms.
   always_comb begin
      logic signed [VOLT_W-1:0] v_cl;
      logic [OFF_W-1:0]         off;
      v_cl = req_adc_microvolt;
      if (req_adc_microvolt < VOLT_MIN) begin
         v_cl = VOLT_MIN;
      end else if (req_adc_microvolt > VOLT_MAX) begin
         v_cl = VOLT_MAX;
      end
      off       = OFF_W'(v_cl - VOLT_MIN);
      s1_res_in = RES_W'(off >> GAIN_SHIFT) + RES_BASE;
   end

   // Pick the first segment whose upper point covers the resistance.
   // Flat or falling segments, the floor and the beyond-table case all
   // reduce to a zero span so the result is the lower temperature alone.
   always_comb begin
      s2_lot_in  = TEMP_W'(TBL_T[USED_POINTS-1]);
      s2_num_in  = '0;
      s2_den_in  = RES_W'(1);
      s2_span_in = '0;
      for (int i = USED_POINTS - 1; i >= 1; i--) begin
         if (s1_res_ff <= RES_W'(TBL_R[i])) begin
            s2_lot_in = TEMP_W'(TBL_T[i-1]);
            if (TBL_R[i] <= TBL_R[i-1] || TBL_T[i] < TBL_T[i-1]) begin
               s2_num_in  = '0;
               s2_den_in  = RES_W'(1);
               s2_span_in = '0;
            end else begin
               s2_num_in  = s1_res_ff - RES_W'(TBL_R[i-1]);
               s2_den_in  = RES_W'(TBL_R[i] - TBL_R[i-1]);
               s2_span_in = SPAN_W'(TBL_T[i] - TBL_T[i-1]);
            end
         end
      end
      if (s1_res_ff <= RES_W'(TBL_R[0])) begin
         s2_lot_in  = TEMP_FLOOR;
         s2_num_in  = '0;
         s2_den_in  = RES_W'(1);
         s2_span_in = '0;
      end
   end

   // Restoring division, DIV_BITS (three) quotient bits per stage.
   always_comb begin
      logic [PROD_W-1:0] rem;
      logic [PROD_W-1:0] cmp;
      logic [QUOT_W-1:0] quo;
      logic [QIDX_W-1:0] sh;
      div_rem_in[0] = '0;
      div_quo_in[0] = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         rem = div_rem_ff[k-1];
         quo = div_quo_ff[k-1];
         for (int j = 0; j < DIV_BITS; j++) begin
            sh  = QIDX_W'(QUOT_W - 1 - ((k - 1) * DIV_BITS + j));
            cmp = PROD_W'(div_den_ff[k-1]) << sh;
            if (rem >= cmp) begin
               rem     = rem - cmp;
               quo[sh] = 1'b1;
            end
         end
         div_rem_in[k] = rem;
         div_quo_in[k] = quo;
      end
   end

   // Final temperature: lower point plus interpolated step.
   assign out_temp_in = div_lot_ff[DIV_STAGES] +
                        $signed(TEMP_W'(div_quo_ff[DIV_STAGES]));

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_vld_ff[k] <= 1'b0;
         end
      end else begin
         s1_vld_ff     <= accept;
         s2_vld_ff     <= s1_vld_ff;
         div_vld_ff[0] <= s2_vld_ff;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            div_vld_ff[k] <= div_vld_ff[k-1];
         end
         out_vld_ff <= div_vld_ff[DIV_STAGES];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_res_ff <= s1_res_in;

      s2_res_ff  <= s1_res_ff;
      s2_num_ff  <= s2_num_in;
      s2_den_ff  <= s2_den_in;
      s2_span_ff <= s2_span_in;
      s2_lot_ff  <= s2_lot_in;

      // The product register feeds the division pipeline.
      div_rem_ff[0] <= PROD_W'(s2_num_ff) * PROD_W'(s2_span_ff);
      div_quo_ff[0] <= div_quo_in[0];
      div_den_ff[0] <= s2_den_ff;
      div_lot_ff[0] <= s2_lot_ff;
      div_res_ff[0] <= s2_res_ff;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         div_rem_ff[k] <= div_rem_in[k];
         div_quo_ff[k] <= div_quo_in[k];
         div_den_ff[k] <= div_den_ff[k-1];
         div_lot_ff[k] <= div_lot_ff[k-1];
         div_res_ff[k] <= div_res_ff[k-1];
      end

      out_temp_ff <= out_temp_in;
      out_res_ff  <= div_res_ff[DIV_STAGES];
   end

   assign rsp_strobe   = out_vld_ff;
   assign rsp_temp_cc  = out_temp_ff;
   assign rsp_res_mohm = out_res_ff;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the RTD voltage to temperature converter.
`timescale 1ns / 100ps

module testbench;

   import rtdv_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 16;
   localparam int RANDOM_ITEMS = 1600;
   localparam int SPAN_LO_UV  = 409600;
   localparam int SPAN_HI_UV  = 1641920;
   localparam int RES_ZERO_MOHM = 80310;
   localparam int UV_PER_MOHM = 16;
   localparam int TEMP_BELOW_CC = -5000;
   localparam int RTD_POINTS  = 14;

   // Sensor curve: resistance in milliohms and temperature in 0.01 C.
   localparam int RTD_RES_MOHM [RTD_POINTS] = '{
      80310, 80600, 82500, 100000, 107800, 113000, 115000,
      115500, 123200, 130900, 138500, 150000, 154000, 157330
   };
   localparam int RTD_TEMP_CC [RTD_POINTS] = '{
      -5000, -4926, -4447, 0, 2002, 3343, 3860,
      3989, 5989, 8001, 9999, 13045, 14111, 15000
   };

   typedef struct {
      logic signed [TEMP_W-1:0] temp_cc;
      logic        [RES_W-1:0]  res_mohm;
   } rtd_reading_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [VOLT_W-1:0] req_adc_microvolt = '0;
   logic busy;
   logic rsp_strobe;
   logic signed [TEMP_W-1:0] rsp_temp_cc;
   logic [RES_W-1:0] rsp_res_mohm;

   logic signed [VOLT_W-1:0] voltage_queue [$];
   rtd_reading_type expected_readings [$];
   logic taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   int idle_cycles = 0;
   int failures = 0;

   rtd_voltage_to_temperature_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_adc_microvolt (req_adc_microvolt),
      .rsp_strobe        (rsp_strobe),
      .rsp_temp_cc       (rsp_temp_cc),
      .rsp_res_mohm      (rsp_res_mohm)
   );

   // Clamps the voltage, converts it to a resistance and interpolates the curve.
   function automatic rtd_reading_type convert_microvolt(logic signed [VOLT_W-1:0] uv);
      rtd_reading_type reading;
      int volts;
      int res;
      int temp;
      bit found;
      volts = uv;
      if (volts < SPAN_LO_UV) volts = SPAN_LO_UV;
      if (volts > SPAN_HI_UV) volts = SPAN_HI_UV;
      res = (volts - SPAN_LO_UV) / UV_PER_MOHM + RES_ZERO_MOHM;
      temp = RTD_TEMP_CC[RTD_POINTS-1];
      found = 1'b0;
      if (res <= RTD_RES_MOHM[0]) begin
         temp = TEMP_BELOW_CC;
         found = 1'b1;
      end
      for (int i = 1; i < RTD_POINTS && !found; i++) begin
         if (res <= RTD_RES_MOHM[i]) begin
            found = 1'b1;
            // A flat or falling segment yields its lower temperature.
            if (RTD_RES_MOHM[i] <= RTD_RES_MOHM[i-1] || RTD_TEMP_CC[i] < RTD_TEMP_CC[i-1])
               temp = RTD_TEMP_CC[i-1];
            else
               temp = RTD_TEMP_CC[i-1] + int'(
                  (longint'(res - RTD_RES_MOHM[i-1]) * (RTD_TEMP_CC[i] - RTD_TEMP_CC[i-1]))
                  / (RTD_RES_MOHM[i] - RTD_RES_MOHM[i-1]));
         end
      end
      reading.temp_cc = temp[TEMP_W-1:0];
      reading.res_mohm = res[RES_W-1:0];
      return reading;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Directed voltages first, then random ones.
   initial begin
      int point_uv;
      int pick;
      voltage_queue.push_back(24'sh800000);
      voltage_queue.push_back(24'sd8388607);
      voltage_queue.push_back(24'sd0);
      voltage_queue.push_back(-24'sd1);
      voltage_queue.push_back(VOLT_W'(SPAN_LO_UV - 1));
      voltage_queue.push_back(VOLT_W'(SPAN_LO_UV + 15));
      voltage_queue.push_back(VOLT_W'(SPAN_LO_UV + 16));
      voltage_queue.push_back(VOLT_W'(SPAN_HI_UV - 1));
      voltage_queue.push_back(VOLT_W'(SPAN_HI_UV + 1));
      voltage_queue.push_back(VOLT_W'(SPAN_HI_UV - 16));
      voltage_queue.push_back(VOLT_W'(SPAN_HI_UV + 16));
      // Every curve point exactly, which includes both ends of the span.
      for (int i = 0; i < RTD_POINTS; i++)
         voltage_queue.push_back(VOLT_W'((RTD_RES_MOHM[i] - RES_ZERO_MOHM) * UV_PER_MOHM
                                         + SPAN_LO_UV));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            voltage_queue.push_back(VOLT_W'($urandom_range(SPAN_LO_UV, SPAN_HI_UV)));
         end else if (pick < 80) begin
            // Hover around a curve point to hit segment boundaries.
            point_uv = (RTD_RES_MOHM[$urandom_range(0, RTD_POINTS-1)] - RES_ZERO_MOHM)
                       * UV_PER_MOHM + SPAN_LO_UV;
            voltage_queue.push_back(VOLT_W'(point_uv + int'($urandom_range(0, 80)) - 40));
         end else begin
            voltage_queue.push_back(VOLT_W'($urandom()));
         end
      end
   end

   // Driver: issues one transaction per cycle in bursts separated by gaps, holding each until it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // Hold the current transaction until it is accepted.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else if (voltage_queue.size() > 0) begin
         req_adc_microvolt <= voltage_queue.pop_front();
         start <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: records accepted transactions and checks every result.
   always @(posedge clock) begin
      rtd_reading_type want;
      taken <= !reset && start && busy === 1'b0;
      if (!reset && start && busy === 1'b0)
         expected_readings.push_back(convert_microvolt(req_adc_microvolt));
      if (!reset && $isunknown(rsp_strobe)) begin
         $display("%0t: rsp_strobe is unknown", $time);
         failures++;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected result temp %0d res %0d", $time,
                     rsp_temp_cc, rsp_res_mohm);
            failures++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_temp_cc !== want.temp_cc) begin
               $display("%0t: temperature expected %0d actual %0d", $time,
                        want.temp_cc, rsp_temp_cc);
               failures++;
            end
            if (rsp_res_mohm !== want.res_mohm) begin
               $display("%0t: resistance expected %0d actual %0d", $time,
                        want.res_mohm, rsp_res_mohm);
               failures++;
            end
         end
      end
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // End of run: drain all stimulus and results, then report.
   initial begin
      @(negedge clock);
      while (reset || voltage_queue.size() != 0 || start) @(negedge clock);
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (failures == 0 && expected_readings.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[rtd_voltage_to_temperature_core.f]
rtl/rtdv_pkg.sv
rtl/rtd_voltage_to_temperature_core.sv
sim/testbench.sv
